// ----- rtl/kab_pkg.sv -----
// shared item types, register codes and fixed-point constants for the angle/bias filter
package kab_pkg;

  // fraction bits of covariance entries and gains
  localparam int FRAC_COV = 28;

  // configuration register port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd3;

  // register reset values, unsigned Q3.28
  localparam logic [CFG_DATA_W-1:0] RST_ANGLE_NOISE = 31'd268435;
  localparam logic [CFG_DATA_W-1:0] RST_BIAS_NOISE  = 31'd805306;
  localparam logic [CFG_DATA_W-1:0] RST_MEAS_NOISE  = 31'd134217728;
  localparam logic [CFG_DATA_W-1:0] RST_TIME_STEP   = 31'd1073742;

  // input item: accelerometer angle and gyro rate, signed Q12.20
  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
  } in_item_t;

  // result item: filtered angle, gyro bias, saturation flag
  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
    logic               overflow_flag;
  } out_item_t;

endpackage

// ----- rtl/kab_mul.sv -----
// bit-serial signed multiplier with round-to-nearest rescale and saturation
module kab_mul #(
  parameter int W  = 32,
  parameter int MW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [MW:0]  a,
  input  logic signed [MW:0]  b,
  output logic                done,
  output logic signed [W-1:0] prod,
  output logic                ovf
);

  localparam int PW = 2 * MW;
  localparam int CW = $clog2(MW + 1);
  localparam int FR = kab_pkg::FRAC_COV;
  localparam int MAGW = PW - FR;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [MW-1:0] am_r;
  logic [MW-1:0] bsh_r;
  logic [PW-1:0] acc_r;
  logic [W-1:0]  prod_r;
  logic          ovf_r;

  logic [MW:0]   a_abs;
  logic [MW:0]   b_abs;
  logic [MW:0]   psum;
  logic [PW-1:0] acc_nxt;
  logic [PW-1:0] rnd;
  logic [MAGW-1:0] mag;
  logic [W-1:0]  lim;
  logic          over;
  logic [W-1:0]  sel;
  logic [W-1:0]  res;

  // operand magnitudes
  assign a_abs = a[MW] ? (-a) : a;
  assign b_abs = b[MW] ? (-b) : b;

  // one multiplier bit per cycle, product shifts in from the top
  assign psum    = {1'b0, acc_r[PW-1:MW]} + {1'b0, (bsh_r[0] ? am_r : {MW{1'b0}})};
  assign acc_nxt = {psum, acc_r[MW-1:1]};

  // round half away from zero on the magnitude, drop fraction, saturate
  assign rnd  = acc_r + ({{(PW-1){1'b0}}, 1'b1} << (FR - 1));
  assign mag  = rnd[PW-1:FR];
  assign lim  = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg_r};
  assign over = (|mag[MAGW-1:W]) || (mag[W-1:0] > lim);
  assign sel  = over ? lim : mag[W-1:0];
  assign res  = neg_r ? (~sel + {{(W-1){1'b0}}, 1'b1}) : sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        am_r   <= a_abs[MW-1:0];
        bsh_r  <= b_abs[MW-1:0];
        acc_r  <= '0;
        neg_r  <= a[MW] ^ b[MW];
      end else if (busy_r) begin
        if (cnt_r == CW'(MW)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          prod_r <= res;
          ovf_r  <= over;
        end else begin
          acc_r <= acc_nxt;
          bsh_r <= {1'b0, bsh_r[MW-1:1]};
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;
  assign ovf  = ovf_r;

endmodule

// ----- rtl/kab_div.sv -----
// bit-serial restoring divider for (n << 28) / d, truncating, saturated, zero on zero divisor
module kab_div #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] n,
  input  logic signed [W-1:0] d,
  output logic                done,
  output logic signed [W-1:0] quot,
  output logic                ovf
);

  localparam int FR = kab_pkg::FRAC_COV;
  localparam int NB = W + FR;
  localparam int CW = $clog2(NB + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          zero_r;
  logic          big_r;
  logic [NB-1:0] num_r;
  logic [W-1:0]  ud_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  quot_r;
  logic          ovf_r;

  logic [W-1:0]  un;
  logic [W-1:0]  ud;
  logic [W:0]    rs;
  logic [W:0]    rdiff;
  logic          ge;
  logic [W-1:0]  lim;
  logic          over;
  logic [W-1:0]  sel;
  logic [W-1:0]  res;

  assign un = n[W-1] ? (-n) : n;
  assign ud = d[W-1] ? (-d) : d;

  // one quotient bit per cycle
  assign rs    = {rem_r, num_r[NB-1]};
  assign rdiff = rs - {1'b0, ud_r};
  assign ge    = (rs >= {1'b0, ud_r});

  // saturate the magnitude and apply the sign
  assign lim  = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg_r};
  assign over = big_r || (q_r > lim);
  assign sel  = over ? lim : q_r;
  assign res  = neg_r ? (~sel + {{(W-1){1'b0}}, 1'b1}) : sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= n[W-1] ^ d[W-1];
        zero_r <= (d == '0);
        big_r  <= 1'b0;
        num_r  <= {un, {FR{1'b0}}};
        ud_r   <= ud;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(NB)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= zero_r ? '0 : res;
          ovf_r  <= !zero_r && over;
        end else begin
          rem_r <= ge ? rdiff[W-1:0] : rs[W-1:0];
          q_r   <= {q_r[W-2:0], ge};
          big_r <= big_r | q_r[W-1];
          num_r <= {num_r[NB-2:0], 1'b0};
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign ovf  = ovf_r;

endmodule

// ----- rtl/kalman_angle_bias_filter.sv -----
// top level: two-state angle/gyro-bias filter with a serial multiply/divide sequencer
//
//   channel  direction  handshake            payload
//   in_      in         in_valid / in_stall  in_data   (kab_pkg::in_item_t)
//   out_     out        out_valid / out_stall out_data (kab_pkg::out_item_t)
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. The bit-serial multiplier (ten products) and the restoring
// divider (two gains) do the arithmetic; MW is the larger of DATA_WIDTH and 31.
// Reset is synchronous, active low, and restores the register defaults and filter
// state. A finished item waits in the output register while out_stall is high;
// the next input item is taken meanwhile.
module kalman_angle_bias_filter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  kab_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output kab_pkg::out_item_t                     out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kab_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [kab_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int W   = DATA_WIDTH;
  localparam int MW  = (W > 31) ? W : 31;
  localparam int OPW = MW + 1;
  localparam int SW  = MW + 2;
  localparam int CFW = kab_pkg::CFG_DATA_W;

  localparam logic signed [SW-1:0] HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] LO = ~HI;
  localparam logic signed [SW-1:0] O_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] O_LO = ~O_HI;
  localparam logic signed [SW-1:0] ONE_SW = {{(SW-1){1'b0}}, 1'b1} << kab_pkg::FRAC_COV;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // step codes
  localparam logic [3:0] OP_PRED_ANGLE = 4'd0;
  localparam logic [3:0] OP_PRED_AA    = 4'd1;
  localparam logic [3:0] OP_PRED_AB    = 4'd2;
  localparam logic [3:0] OP_PRED_BB    = 4'd3;
  localparam logic [3:0] OP_GAIN_K0    = 4'd4;
  localparam logic [3:0] OP_GAIN_K1    = 4'd5;
  localparam logic [3:0] OP_UPD_BA     = 4'd6;
  localparam logic [3:0] OP_UPD_BB     = 4'd7;
  localparam logic [3:0] OP_UPD_AA     = 4'd8;
  localparam logic [3:0] OP_UPD_AB     = 4'd9;
  localparam logic [3:0] OP_CORR_ANGLE = 4'd10;
  localparam logic [3:0] OP_CORR_BIAS  = 4'd11;

  function automatic logic signed [SW-1:0] sxw(input logic signed [W-1:0] v);
    sxw = {{(SW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] sx32(input logic signed [31:0] v);
    sx32 = {{(SW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] zx31(input logic [CFW-1:0] v);
    zx31 = {{(SW-CFW){1'b0}}, v};
  endfunction

  function automatic logic signed [OPW-1:0] opx(input logic signed [W-1:0] v);
    opx = {{(OPW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] clampv(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if (v > HI) r = HI[W-1:0];
    else if (v < LO) r = LO[W-1:0];
    else r = v[W-1:0];
    clampv = r;
  endfunction

  function automatic logic clampf(input logic signed [SW-1:0] v);
    clampf = (v > HI) || (v < LO);
  endfunction

  function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
    logic signed [SW-1:0] e;
    logic signed [31:0]   r;
    e = sxw(v);
    if (e > O_HI) r = O_HI[31:0];
    else if (e < O_LO) r = O_LO[31:0];
    else r = e[31:0];
    out32 = r;
  endfunction

  function automatic logic out32f(input logic signed [W-1:0] v);
    out32f = (sxw(v) > O_HI) || (sxw(v) < O_LO);
  endfunction

  // control and configuration
  logic [1:0]     state_r, state_nxt;
  logic [3:0]     op_r, op_nxt;
  logic [CFW-1:0] apn_r, bpn_r, mn_r, dt_r;
  logic           ovf_r, ovf_nxt;
  logic           out_valid_r, out_valid_nxt;
  kab_pkg::out_item_t out_data_r, out_data_nxt;

  // filter state and per-item values
  logic signed [W-1:0] meas_r, meas_nxt;
  logic signed [W-1:0] rate_r, rate_nxt;
  logic signed [W-1:0] angle_r, angle_nxt;
  logic signed [W-1:0] bias_r, bias_nxt;
  logic signed [W-1:0] caa_r, caa_nxt;
  logic signed [W-1:0] cab_r, cab_nxt;
  logic signed [W-1:0] cba_r, cba_nxt;
  logic signed [W-1:0] cbb_r, cbb_nxt;
  logic signed [W-1:0] k0_r, k0_nxt;
  logic signed [W-1:0] k1_r, k1_nxt;
  logic signed [W-1:0] err_r, err_nxt;
  logic signed [W-1:0] var_r, var_nxt;

  // arithmetic unit hookup
  logic                  mul_start, mul_done, mul_ovf;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [W-1:0]   mul_p;
  logic                  div_start, div_done, div_ovf;
  logic signed [W-1:0]   div_n, div_d, div_q;

  // operand terms
  logic signed [SW-1:0] rb_sum, apn_sum, daa_sum, dab_sum, dbb_sum, err_sum, var_sum;
  logic signed [W-1:0]  var_c;
  logic signed [OPW-1:0] dt_op;

  kab_mul #(.W(W), .MW(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p),
    .ovf   (mul_ovf)
  );

  kab_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .quot  (div_q),
    .ovf   (div_ovf)
  );

  // prediction and gain terms from current state
  always_comb begin
    rb_sum  = sxw(rate_r) - sxw(bias_r);
    apn_sum = zx31(apn_r) - sxw(cab_r);
    daa_sum = sxw(clampv(apn_sum)) - sxw(cba_r);
    dab_sum = -sxw(cbb_r);
    dbb_sum = zx31(bpn_r);
    err_sum = sxw(meas_r) - sxw(angle_r);
    var_sum = zx31(mn_r) + sxw(caa_r);
    var_c   = clampv(var_sum);
    dt_op   = {{(OPW-CFW){1'b0}}, dt_r};
  end

  // operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = caa_r;
    div_d = var_c;
    case (op_r)
      OP_PRED_ANGLE: begin mul_a = opx(clampv(rb_sum)); mul_b = dt_op; end
      OP_PRED_AA:    begin mul_a = opx(clampv(daa_sum)); mul_b = dt_op; end
      OP_PRED_AB:    begin mul_a = opx(clampv(dab_sum)); mul_b = dt_op; end
      OP_PRED_BB:    begin mul_a = opx(clampv(dbb_sum)); mul_b = dt_op; end
      OP_GAIN_K1:    begin div_n = cba_r; div_d = var_r; end
      OP_UPD_BA:     begin mul_a = opx(k1_r); mul_b = opx(caa_r); end
      OP_UPD_BB:     begin mul_a = opx(k1_r); mul_b = opx(cab_r); end
      OP_UPD_AA:     begin mul_a = opx(k0_r); mul_b = opx(caa_r); end
      OP_UPD_AB:     begin mul_a = opx(k0_r); mul_b = opx(cab_r); end
      OP_CORR_ANGLE: begin mul_a = opx(k0_r); mul_b = opx(err_r); end
      OP_CORR_BIAS:  begin mul_a = opx(k1_r); mul_b = opx(err_r); end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ovf_nxt       = ovf_r;
    meas_nxt      = meas_r;
    rate_nxt      = rate_r;
    angle_nxt     = angle_r;
    bias_nxt      = bias_r;
    caa_nxt       = caa_r;
    cab_nxt       = cab_r;
    cba_nxt       = cba_r;
    cbb_nxt       = cbb_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    err_nxt       = err_r;
    var_nxt       = var_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          meas_nxt  = clampv(sx32(in_data.measured_angle));
          rate_nxt  = clampv(sx32(in_data.gyro_rate));
          ovf_nxt   = clampf(sx32(in_data.measured_angle)) | clampf(sx32(in_data.gyro_rate));
          op_nxt    = OP_PRED_ANGLE;
          state_nxt = S_ISSUE;
        end
      end

      S_ISSUE: begin
        state_nxt = S_WAIT;
        case (op_r)
          OP_PRED_ANGLE: begin mul_start = 1'b1; ovf_nxt = ovf_r | clampf(rb_sum); end
          OP_PRED_AA: begin
            mul_start = 1'b1;
            ovf_nxt   = ovf_r | clampf(apn_sum) | clampf(daa_sum);
          end
          OP_PRED_AB: begin mul_start = 1'b1; ovf_nxt = ovf_r | clampf(dab_sum); end
          OP_PRED_BB: begin mul_start = 1'b1; ovf_nxt = ovf_r | clampf(dbb_sum); end
          OP_GAIN_K0: begin
            div_start = 1'b1;
            err_nxt   = clampv(err_sum);
            var_nxt   = var_c;
            ovf_nxt   = ovf_r | clampf(err_sum) | clampf(var_sum);
          end
          OP_GAIN_K1: div_start = 1'b1;
          default: mul_start = 1'b1;
        endcase
      end

      S_WAIT: begin
        if (mul_done || div_done) begin
          case (op_r)
            OP_PRED_ANGLE: begin
              angle_nxt = clampv(sxw(angle_r) + sxw(mul_p));
              ovf_nxt   = ovf_r | mul_ovf | clampf(sxw(angle_r) + sxw(mul_p));
            end
            OP_PRED_AA: begin
              caa_nxt = clampv(sxw(caa_r) + sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(caa_r) + sxw(mul_p));
            end
            OP_PRED_AB: begin
              cab_nxt = clampv(sxw(cab_r) + sxw(mul_p));
              cba_nxt = clampv(sxw(cba_r) + sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(cab_r) + sxw(mul_p))
                        | clampf(sxw(cba_r) + sxw(mul_p));
            end
            OP_PRED_BB: begin
              cbb_nxt = clampv(sxw(cbb_r) + sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(cbb_r) + sxw(mul_p));
            end
            OP_GAIN_K0: begin k0_nxt = div_q; ovf_nxt = ovf_r | div_ovf; end
            OP_GAIN_K1: begin k1_nxt = div_q; ovf_nxt = ovf_r | div_ovf; end
            OP_UPD_BA: begin
              cba_nxt = clampv(sxw(cba_r) - sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(cba_r) - sxw(mul_p));
            end
            OP_UPD_BB: begin
              cbb_nxt = clampv(sxw(cbb_r) - sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(cbb_r) - sxw(mul_p));
            end
            OP_UPD_AA: begin
              caa_nxt = clampv(sxw(caa_r) - sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(caa_r) - sxw(mul_p));
            end
            OP_UPD_AB: begin
              cab_nxt = clampv(sxw(cab_r) - sxw(mul_p));
              ovf_nxt = ovf_r | mul_ovf | clampf(sxw(cab_r) - sxw(mul_p));
            end
            OP_CORR_ANGLE: begin
              angle_nxt = clampv(sxw(angle_r) + sxw(mul_p));
              ovf_nxt   = ovf_r | mul_ovf | clampf(sxw(angle_r) + sxw(mul_p));
            end
            OP_CORR_BIAS: begin
              bias_nxt = clampv(sxw(bias_r) + sxw(mul_p));
              ovf_nxt  = ovf_r | mul_ovf | clampf(sxw(bias_r) + sxw(mul_p));
            end
            default: ;
          endcase
          if (op_r == OP_CORR_BIAS) begin
            state_nxt = S_DONE;
          end else begin
            op_nxt    = op_r + 4'd1;
            state_nxt = S_ISSUE;
          end
        end
      end

      S_DONE: begin
        // hand the item to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.angle_estimate = out32(angle_r);
          out_data_nxt.bias_estimate  = out32(bias_r);
          out_data_nxt.overflow_flag  = ovf_r | out32f(angle_r) | out32f(bias_r);
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apn_r <= kab_pkg::RST_ANGLE_NOISE;
      bpn_r <= kab_pkg::RST_BIAS_NOISE;
      mn_r  <= kab_pkg::RST_MEAS_NOISE;
      dt_r  <= kab_pkg::RST_TIME_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kab_pkg::REG_ANGLE_NOISE: apn_r <= cfg_data;
        kab_pkg::REG_BIAS_NOISE:  bpn_r <= cfg_data;
        kab_pkg::REG_MEAS_NOISE:  mn_r  <= cfg_data;
        kab_pkg::REG_TIME_STEP:   dt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PRED_ANGLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      bias_r      <= '0;
      caa_r       <= clampv(ONE_SW);
      cab_r       <= '0;
      cba_r       <= '0;
      cbb_r       <= clampv(ONE_SW);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      bias_r      <= bias_nxt;
      caa_r       <= caa_nxt;
      cab_r       <= cab_nxt;
      cba_r       <= cba_nxt;
      cbb_r       <= cbb_nxt;
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    rate_r     <= rate_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    err_r      <= err_nxt;
    var_r      <= var_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the angle/gyro-bias filter: scoreboard, stimulus and checks
module tb_top;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES   = 600;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 240;
  // first index past the register file; writes there must be dropped
  localparam logic [kab_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd4;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MAX = -64'sd2147483648;

  // expected-result tracker with its own copy of filter state and registers
  class kab_scoreboard;
    longint angle_noise, bias_noise, meas_noise, step_dt;
    longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
    bit sat;
    kab_pkg::out_item_t pending[$];
    int errors;
    int checked;

    function void clear();
      angle_noise = longint'(kab_pkg::RST_ANGLE_NOISE);
      bias_noise  = longint'(kab_pkg::RST_BIAS_NOISE);
      meas_noise  = longint'(kab_pkg::RST_MEAS_NOISE);
      step_dt     = longint'(kab_pkg::RST_TIME_STEP);
      angle_est = 0;
      bias_est  = 0;
      p_aa = longint'(1) << kab_pkg::FRAC_COV;
      p_ab = 0;
      p_ba = 0;
      p_bb = longint'(1) << kab_pkg::FRAC_COV;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [kab_pkg::CFG_IDX_W-1:0] idx,
                            logic [kab_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        kab_pkg::REG_ANGLE_NOISE: angle_noise = longint'(val);
        kab_pkg::REG_BIAS_NOISE:  bias_noise  = longint'(val);
        kab_pkg::REG_MEAS_NOISE:  meas_noise  = longint'(val);
        kab_pkg::REG_TIME_STEP:   step_dt     = longint'(val);
        default: ;
      endcase
    endfunction

    // saturate to the 32-bit datapath
    function longint clip(longint v);
      if (v > POS_MAX) begin
        sat = 1;
        return POS_MAX;
      end
      if (v < NEG_MAX) begin
        sat = 1;
        return NEG_MAX;
      end
      return v;
    endfunction

    // signed value from sign and magnitude, saturating
    function longint from_mag(bit neg, logic [127:0] m);
      logic [127:0] lim;
      lim = 128'(POS_MAX) + 128'(neg);
      if (m > lim) begin
        sat = 1;
        m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // Q.28 product, rounded half away from zero
    function longint fxmul(longint a, longint b);
      logic [127:0] ua, ub, p;
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      p = (ua * ub + (128'd1 << (kab_pkg::FRAC_COV - 1))) >> kab_pkg::FRAC_COV;
      return from_mag((a < 0) != (b < 0), p);
    endfunction

    // Q.28 quotient truncated toward zero, zero divisor gives zero
    function longint fxdiv(longint n, longint d);
      logic [127:0] un, ud;
      if (d == 0) return 0;
      un = 128'(n < 0 ? -n : n);
      ud = 128'(d < 0 ? -d : d);
      return from_mag((n < 0) != (d < 0), (un << kab_pkg::FRAC_COV) / ud);
    endfunction

    function void note_input(kab_pkg::in_item_t x);
      longint meas, rate, d_aa, d_ab, err, var_s, k0, k1, t0, t1;
      kab_pkg::out_item_t y;
      sat = 0;
      meas = longint'(x.measured_angle);
      rate = longint'(x.gyro_rate);
      // predict
      angle_est = clip(angle_est + fxmul(clip(rate - bias_est), step_dt));
      d_aa = clip(clip(angle_noise - p_ab) - p_ba);
      d_ab = clip(-p_bb);
      p_aa = clip(p_aa + fxmul(d_aa, step_dt));
      p_ab = clip(p_ab + fxmul(d_ab, step_dt));
      p_ba = clip(p_ba + fxmul(d_ab, step_dt));
      p_bb = clip(p_bb + fxmul(clip(bias_noise), step_dt));
      // gains
      err = clip(meas - angle_est);
      var_s = clip(meas_noise + p_aa);
      k0 = fxdiv(p_aa, var_s);
      k1 = fxdiv(p_ba, var_s);
      // covariance update
      t0 = p_aa;
      t1 = p_ab;
      p_aa = clip(p_aa - fxmul(k0, t0));
      p_ab = clip(p_ab - fxmul(k0, t1));
      p_ba = clip(p_ba - fxmul(k1, t0));
      p_bb = clip(p_bb - fxmul(k1, t1));
      // correction
      angle_est = clip(angle_est + fxmul(k0, err));
      bias_est  = clip(bias_est + fxmul(k1, err));
      y.angle_estimate = angle_est[31:0];
      y.bias_estimate  = bias_est[31:0];
      y.overflow_flag  = sat;
      pending.push_back(y);
    endfunction

    function void check_result(kab_pkg::out_item_t got);
      kab_pkg::out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected item angle %h bias %h ovf %b", $time,
                 got.angle_estimate, got.bias_estimate, got.overflow_flag);
        return;
      end
      want = pending.pop_front();
      if (got.angle_estimate !== want.angle_estimate) begin
        errors++;
        $display("%0t: angle_estimate expected %h actual %h", $time,
                 want.angle_estimate, got.angle_estimate);
      end
      if (got.bias_estimate !== want.bias_estimate) begin
        errors++;
        $display("%0t: bias_estimate expected %h actual %h", $time,
                 want.bias_estimate, got.bias_estimate);
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        errors++;
        $display("%0t: overflow_flag expected %b actual %b", $time,
                 want.overflow_flag, got.overflow_flag);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  kab_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  kab_pkg::out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [kab_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kab_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  kab_scoreboard sb = new();
  bit quiet = 0;
  int sent = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  kalman_angle_bias_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !quiet && ($urandom_range(99) < 25);
  end

  // watchdog on cycles without any accepted item or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(kab_pkg::in_item_t x);
    int gap;
    gap = (!quiet && $urandom_range(99) < 25) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
    sent++;
  endtask

  // stop input and let every pending result drain
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [kab_pkg::CFG_IDX_W-1:0] idx,
                           logic [kab_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [kab_pkg::CFG_DATA_W-1:0] pick_reg(
      logic [kab_pkg::CFG_DATA_W-1:0] dflt);
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return dflt;
      3: return kab_pkg::CFG_DATA_W'($urandom_range(0, 32'h1000_0000));
      default: return kab_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic kab_pkg::in_item_t pick_item();
    kab_pkg::in_item_t x;
    if ($urandom_range(99) < 80) begin
      // plausible sensor data: within about 200 degrees and deg/s
      x.measured_angle = $signed($urandom_range(0, 32'h1900_0000)) - 32'sh0C80_0000;
      x.gyro_rate      = $signed($urandom_range(0, 32'h1900_0000)) - 32'sh0C80_0000;
    end else begin
      x.measured_angle = $urandom;
      x.gyro_rate      = $urandom;
    end
    return x;
  endfunction

  initial begin
    logic [31:0] corner [5];
    kab_pkg::in_item_t x;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000};
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // field extremes with default registers
    foreach (corner[i]) begin
      x.measured_angle = corner[i];
      x.gyro_rate = corner[(i + 2) % 5];
      send_item(x);
    end
    drain();

    // no measurement noise and no time step: gain of one, then zero variance
    write_reg(kab_pkg::REG_MEAS_NOISE, '0);
    write_reg(kab_pkg::REG_TIME_STEP, '0);
    write_reg(REG_FIRST_UNUSED, '1);
    for (int i = 0; i < 4; i++) begin
      x.measured_angle = corner[i];
      x.gyro_rate = corner[4 - i];
      send_item(x);
    end
    drain();

    // largest noises and time step: saturation and negative variance
    write_reg(kab_pkg::REG_ANGLE_NOISE, '1);
    write_reg(kab_pkg::REG_BIAS_NOISE, '1);
    write_reg(kab_pkg::REG_TIME_STEP, '1);
    for (int i = 0; i < 6; i++) begin
      x.measured_angle = corner[i % 5];
      x.gyro_rate = corner[(i + 1) % 5];
      send_item(x);
    end
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(kab_pkg::REG_ANGLE_NOISE, pick_reg(kab_pkg::RST_ANGLE_NOISE));
      write_reg(kab_pkg::REG_BIAS_NOISE, pick_reg(kab_pkg::RST_BIAS_NOISE));
      write_reg(kab_pkg::REG_MEAS_NOISE, pick_reg(kab_pkg::RST_MEAS_NOISE));
      write_reg(kab_pkg::REG_TIME_STEP, pick_reg(kab_pkg::RST_TIME_STEP));
      write_reg(kab_pkg::CFG_IDX_W'($urandom_range(4, 7)), kab_pkg::CFG_DATA_W'($urandom));
      quiet = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(pick_item());
      drain();
      quiet = 0;
    end

    $display("covered %0d items, %0d results checked, %0d register writes", sent,
             sb.checked, reg_writes);
    $display("registers: defaults, zero and full scale, then %0d random phases", PHASES);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/kab_pkg.sv
rtl/kab_mul.sv
rtl/kab_div.sv
rtl/kalman_angle_bias_filter.sv
test/tb_top.sv
